### hw/rtl/jsu_pkg.sv
// Package for the JSON string unescaper: word types, result codes, byte constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_t;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // All results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        out_t [MAX_RESULTS-1:0]      items;
    } run_t;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_EXPECTED = 3'd0;
    localparam logic [2:0] ERR_CHAR     = 3'd1;
    localparam logic [2:0] ERR_UNICODE  = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

### hw/rtl/jsu_decode.sv
// Byte decoder: parser state registers and the per-byte result logic.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  jsu_pkg::in_t  in_word,
    output jsu_pkg::run_t run
);
    import jsu_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;

    function automatic out_t mk_item(input logic [1:0] kind, input logic [7:0] data,
                                     input logic [2:0] err);
        out_t o;
        o.kind        = kind;
        o.data_byte   = data;
        o.error_code  = err;
        o.last_of_run = 1'b0;
        return o;
    endfunction

    logic [7:0]       b;
    logic             fin;
    logic [CNT_W-1:0] n;
    out_t [MAX_RESULTS-1:0] items;
    logic             hex_ok;
    logic [3:0]       hex_val;
    logic             esc_ok;
    logic [7:0]       esc_d;
    logic [15:0]      cp;

    assign b   = in_word.in_byte;
    assign fin = in_word.final_byte;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hex_val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            hex_val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            hex_val = 4'(b - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        esc_ok = 1'b1;
        esc_d  = b;
        unique case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_d = b;
            CH_B:    esc_d = 8'h08;
            CH_F:    esc_d = 8'h0c;
            CH_N:    esc_d = 8'h0a;
            CH_R:    esc_d = 8'h0d;
            CH_T:    esc_d = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign cp = {code_accum_reg[11:0], hex_val};

    always_comb
    begin
        items           = '0;
        n               = '0;
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;

        unique case (mode_reg)
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    mode_next = MODE_IDLE;
                    items[n[1:0]] = mk_item(KIND_CLOSED, 8'h00, 3'd0);
                    n = n + CNT_W'(1);
                end
                else if (b < CH_SPACE)
                begin
                    mode_next = MODE_IDLE;
                    items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_CHAR);
                    n = n + CNT_W'(1);
                end
                else if (b == CH_BSLASH)
                begin
                    if (fin)
                    begin
                        mode_next = MODE_IDLE;
                        items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNTERM);
                        n = n + CNT_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_ESC;
                    end
                end
                else
                begin
                    items[n[1:0]] = mk_item(KIND_DATA, b, 3'd0);
                    n = n + CNT_W'(1);
                    if (fin)
                    begin
                        mode_next = MODE_IDLE;
                        items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNTERM);
                        n = n + CNT_W'(1);
                    end
                end
            end
            MODE_ESC:
            begin
                if (b == CH_U)
                begin
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'h0000;
                    if (fin)
                    begin
                        mode_next = MODE_IDLE;
                        items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNICODE);
                        n = n + CNT_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_HEX;
                    end
                end
                else if (!esc_ok)
                begin
                    mode_next = MODE_IDLE;
                    items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_ESCAPE);
                    n = n + CNT_W'(1);
                end
                else
                begin
                    mode_next = MODE_STR;
                    items[n[1:0]] = mk_item(KIND_DATA, esc_d, 3'd0);
                    n = n + CNT_W'(1);
                    if (fin)
                    begin
                        mode_next = MODE_IDLE;
                        items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNTERM);
                        n = n + CNT_W'(1);
                    end
                end
            end
            MODE_HEX:
            begin
                if (!hex_ok)
                begin
                    mode_next = MODE_IDLE;
                    items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNICODE);
                    n = n + CNT_W'(1);
                end
                else
                begin
                    code_accum_next = cp;
                    if (hex_count_reg == 2'd3)
                    begin
                        hex_count_next = 2'd0;
                        mode_next      = MODE_STR;
                        if (cp[15:7] == '0)
                        begin
                            items[n[1:0]] = mk_item(KIND_DATA, cp[7:0], 3'd0);
                            n = n + CNT_W'(1);
                        end
                        else if (cp[15:11] == '0)
                        begin
                            items[n[1:0]] = mk_item(KIND_DATA, {3'b110, cp[10:6]}, 3'd0);
                            n = n + CNT_W'(1);
                            items[n[1:0]] = mk_item(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
                            n = n + CNT_W'(1);
                        end
                        else
                        begin
                            items[n[1:0]] = mk_item(KIND_DATA, {4'b1110, cp[15:12]}, 3'd0);
                            n = n + CNT_W'(1);
                            items[n[1:0]] = mk_item(KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
                            n = n + CNT_W'(1);
                            items[n[1:0]] = mk_item(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
                            n = n + CNT_W'(1);
                        end
                        if (fin)
                        begin
                            mode_next = MODE_IDLE;
                            items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNTERM);
                            n = n + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                        if (fin)
                        begin
                            mode_next = MODE_IDLE;
                            items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNICODE);
                            n = n + CNT_W'(1);
                        end
                    end
                end
            end
            MODE_IDLE:
            begin
                if (b != CH_QUOTE)
                begin
                    items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_EXPECTED);
                    n = n + CNT_W'(1);
                end
                else if (fin)
                begin
                    items[n[1:0]] = mk_item(KIND_ERROR, 8'h00, ERR_UNTERM);
                    n = n + CNT_W'(1);
                end
                else
                begin
                    mode_next = MODE_STR;
                end
            end
        endcase

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            items[i].last_of_run = (CNT_W'(i + 1) == n);
        end
    end

    assign run.count = n;
    assign run.items = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'h0000;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
        end
    end

endmodule

### hw/rtl/jsu_run_buf.sv
// Result register: holds the run of results for one byte and hands them out one word a cycle while out_ready is high.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_run_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  jsu_pkg::run_t run,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output jsu_pkg::out_t out_data
);
    import jsu_pkg::*;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    out_t [MAX_RESULTS-1:0] items_reg, items_next;
    logic                   pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = items_reg[0];
    assign pop       = out_valid && out_ready;
    // free now, or the last word leaves this cycle
    assign can_load  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        items_next = items_reg;
        if (load)
        begin
            cnt_next   = run.count;
            items_next = run.items;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                items_next[i] = items_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

### hw/rtl/json_string_unescaper.sv
// Top level of the JSON string unescaper: decoder feeding the result register.
// Depends on jsu_pkg, jsu_decode, jsu_run_buf.
`timescale 1ns / 1ps

// Takes one raw byte of a quoted JSON string per in word and gives the decoded bytes, a
// closed word at the closing quote, or an error word, each run's last word flagged with
// last_of_run. Results are registered and appear in the cycle after the byte is taken. Plain
// text streams at one byte per cycle while out_ready is high; a byte causing k results holds
// in_ready low until the four-entry result register has drained to its last word, one word per
// cycle while out_ready is high (k is at most 4, on the last digit of a \u escape with final set).
// in_ready follows out_ready combinationally when one word is left in the result register.
module json_string_unescaper (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  jsu_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output jsu_pkg::out_t out_data
);
    import jsu_pkg::*;

    run_t run;
    logic accept;

    assign accept = in_valid && in_ready;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (in_data),
        .run     (run)
    );

    jsu_run_buf u_run_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .run       (run),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper.
`timescale 1ns / 1ps

module jsu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input jsu_pkg::out_t out_data
);
    import jsu_pkg::*;

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // closed and error words always end their run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_DATA |-> out_data.last_of_run)
        else $error("closed or error word not last of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_DATA |-> out_data.data_byte == 8'h00)
        else $error("data byte set on non-data word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_ERROR |-> out_data.error_code == 3'd0)
        else $error("error code set on non-error word");

    // input side stays blocked while more than one word is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |-> !in_ready)
        else $error("input taken mid-run");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);

### tb/testbench.sv
// Testbench for json_string_unescaper: directed and random byte streams with random stalls on
// both sides. A scoreboard class decodes each accepted byte and checks every result word.
// Depends on jsu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 72;
    localparam int HOLD_CYCLES  = 80;

    // Decoder state plus the queue of result words still owed by the block
    class unescape_tracker;
        logic [1:0]  mode;
        logic [1:0]  hex_count;
        logic [15:0] code_accum;
        out_t        owed_words[$];
        int          fails;
        int          bytes_taken;
        int          words_seen;
        int          closes_seen;
        int          errors_seen;

        function new();
            mode        = MODE_IDLE;
            hex_count   = '0;
            code_accum  = '0;
            fails       = 0;
            bytes_taken = 0;
            words_seen  = 0;
            closes_seen = 0;
            errors_seen = 0;
        endfunction

        function void owe(input logic [1:0] kind, input logic [7:0] data,
                          input logic [2:0] err);
            out_t w;
            w.kind        = kind;
            w.data_byte   = data;
            w.error_code  = err;
            w.last_of_run = 1'b0;
            owed_words.push_back(w);
        endfunction

        function void abort(input logic [2:0] err);
            mode = MODE_IDLE;
            owe(KIND_ERROR, 8'h00, err);
        endfunction

        function int nibble_of(input logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
            if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
            if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
            return -1;
        endfunction

        // Decode one accepted byte and queue the words it should produce
        function void take_byte(input in_t w);
            logic [7:0]  b;
            logic        fin;
            logic [7:0]  d;
            logic        simple;
            logic [15:0] cp;
            int          v;
            int          start;
            out_t        tail;
            b     = w.in_byte;
            fin   = w.final_byte;
            start = owed_words.size();
            bytes_taken++;
            case (mode)
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        mode = MODE_IDLE;
                        owe(KIND_CLOSED, 8'h00, 3'd0);
                    end
                    else if (b < CH_SPACE) abort(ERR_CHAR);
                    else if (b == CH_BSLASH) begin
                        if (fin) abort(ERR_UNTERM);
                        else mode = MODE_ESC;
                    end
                    else begin
                        owe(KIND_DATA, b, 3'd0);
                        if (fin) abort(ERR_UNTERM);
                    end
                end
                MODE_ESC: begin
                    if (b == CH_U) begin
                        hex_count  = '0;
                        code_accum = '0;
                        if (fin) abort(ERR_UNICODE);
                        else mode = MODE_HEX;
                    end
                    else begin
                        simple = 1'b1;
                        d      = b;
                        case (b)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: d = b;
                            CH_B:    d = 8'h08;
                            CH_F:    d = 8'h0c;
                            CH_N:    d = 8'h0a;
                            CH_R:    d = 8'h0d;
                            CH_T:    d = 8'h09;
                            default: simple = 1'b0;
                        endcase
                        if (simple) begin
                            mode = MODE_STR;
                            owe(KIND_DATA, d, 3'd0);
                            if (fin) abort(ERR_UNTERM);
                        end
                        else abort(ERR_ESCAPE);
                    end
                end
                MODE_HEX: begin
                    v = nibble_of(b);
                    if (v < 0) abort(ERR_UNICODE);
                    else begin
                        code_accum = {code_accum[11:0], 4'(v)};
                        if (hex_count == 2'd3) begin
                            cp        = code_accum;
                            hex_count = '0;
                            mode      = MODE_STR;
                            if (cp <= 16'h007f) owe(KIND_DATA, cp[7:0], 3'd0);
                            else if (cp <= 16'h07ff) begin
                                owe(KIND_DATA, {3'b110, cp[10:6]}, 3'd0);
                                owe(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
                            end
                            else begin
                                owe(KIND_DATA, {4'b1110, cp[15:12]}, 3'd0);
                                owe(KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
                                owe(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
                            end
                            if (fin) abort(ERR_UNTERM);
                        end
                        else begin
                            hex_count = hex_count + 2'd1;
                            if (fin) abort(ERR_UNICODE);
                        end
                    end
                end
                default: begin
                    if (b != CH_QUOTE) abort(ERR_EXPECTED);
                    else if (fin) abort(ERR_UNTERM);
                    else mode = MODE_STR;
                end
            endcase
            if (owed_words.size() > start) begin
                tail             = owed_words[owed_words.size() - 1];
                tail.last_of_run = 1'b1;
                owed_words[owed_words.size() - 1] = tail;
            end
        endfunction

        function void match_word(input out_t got);
            out_t want;
            words_seen++;
            if (got.kind == KIND_CLOSED) closes_seen++;
            if (got.kind == KIND_ERROR) errors_seen++;
            if (owed_words.size() == 0) begin
                fails++;
                $display("%0t: unexpected word kind=%0d data=%02h err=%0d last=%0d", $time,
                         got.kind, got.data_byte, got.error_code, got.last_of_run);
                return;
            end
            want = owed_words.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
                fails++;
                $display("%0t: mismatch, expected kind=%0d data=%02h err=%0d last=%0d", $time,
                         want.kind, want.data_byte, want.error_code, want.last_of_run);
                $display("%0t:           actual   kind=%0d data=%02h err=%0d last=%0d", $time,
                         got.kind, got.data_byte, got.error_code, got.last_of_run);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    unescape_tracker tracker;
    logic            idle_on;
    int              hold_reqs;
    int              cycles = 0;

    json_string_unescaper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) tracker.match_word(out_data);
    end

    // Receiver: random stalls, plus one long hold-off when the sender asks for it
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(99) < 32) out_ready <= 1'b0;
            else out_ready <= 1'b1;
        end
    end

    // Offer one word; valid stays high across back-to-back words
    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_t w;
        w.in_byte    = b;
        w.final_byte = fin;
        while (idle_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_byte(w);
    endtask

    function automatic logic stray_final();
        return ($urandom_range(99) < 4);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(7))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_N;
            6:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // Mostly well-formed string with random content; some noise and early finals
    task automatic send_random_string();
        int          parts;
        int          pick;
        logic [7:0]  b;
        logic [15:0] cp;
        send_byte(CH_QUOTE, stray_final());
        parts = $urandom_range(6);
        for (int i = 0; i < parts; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                b = 8'($urandom_range(8'hff, CH_SPACE));
                if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h78;
                send_byte(b, stray_final());
            end
            else if (pick < 70)
            begin
                send_byte(CH_BSLASH, stray_final());
                send_byte(escape_letter(), stray_final());
            end
            else if (pick < 90)
            begin
                // spread code points over the 1, 2 and 3 byte UTF-8 forms
                case ($urandom_range(2))
                    0:       cp = 16'($urandom_range(16'h007f, 0));
                    1:       cp = 16'($urandom_range(16'h07ff, 16'h0080));
                    default: cp = 16'($urandom_range(16'hffff, 16'h0800));
                endcase
                send_byte(CH_BSLASH, stray_final());
                send_byte(CH_U, stray_final());
                send_byte(hex_char(cp[15:12]), stray_final());
                send_byte(hex_char(cp[11:8]), stray_final());
                send_byte(hex_char(cp[7:4]), stray_final());
                send_byte(hex_char(cp[3:0]), stray_final());
            end
            else send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_byte(CH_QUOTE, 1'($urandom_range(1)));
    endtask

    initial
    begin : stimulus
        int  base;
        int  n;
        bit  held;
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        idle_on   = 1'b1;
        hold_reqs = 0;
        held      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-quote while waiting, then opening quote with final
        send_byte(8'h41, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        // data byte with final
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'hff, 1'b1);
        // code point zero
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        repeat (4) send_byte(8'h30, 1'b0);
        // control byte inside a string
        send_byte(8'h00, 1'b0);
        // three UTF-8 bytes and unterminated on the fourth digit: four words from one byte
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(CH_F, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(CH_F, 1'b1);
        // control byte after backslash
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(8'h01, 1'b0);
        // \u with final, incomplete hex with final
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte(8'h61, 1'b1);
        // simple escape with final, backslash with final
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_N, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b1);

        base = tracker.bytes_taken;
        while (tracker.bytes_taken < base + RANDOM_BYTES)
        begin
            n = tracker.bytes_taken - base;
            if (!held && n >= 10)
            begin
                hold_reqs++;
                held = 1'b1;
            end
            idle_on = !(n >= 30 && n < 60);
            if ($urandom_range(99) < 85) send_random_string();
            else send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        in_valid <= 1'b0;
        idle_on = 1'b1;

        while (tracker.owed_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.owed_words.size() != 0)
        begin
            tracker.fails++;
            $display("%0t: %0d expected words never arrived", $time, tracker.owed_words.size());
        end

        $display("Decoded %0d input bytes into %0d result words,", tracker.bytes_taken,
                 tracker.words_seen);
        $display("including %0d closed strings and %0d error words; %0d mismatches.",
                 tracker.closes_seen, tracker.errors_seen, tracker.fails);
        if (tracker.fails == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_run_buf.sv
hw/rtl/json_string_unescaper.sv
hw/rtl/jsu_checker.sv
tb/testbench.sv
